>>> hw/rtl/sha256bc_pkg.sv
package sha256bc_pkg;

   localparam int ROUNDS      = 64;
   localparam int BLOCK_WORDS = 16;
   localparam int HASH_WORDS  = 8;

   localparam int ROUND_W = $clog2(ROUNDS);
   localparam int WIN_W   = $clog2(BLOCK_WORDS);
   localparam int HIDX_W  = $clog2(HASH_WORDS);

   typedef enum logic [0:0] {
      OP_CHAIN = 1'b0,
      OP_MSG   = 1'b1
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [2:0]       word_index;
      logic [31:0]      data;
   } req_type;

   typedef struct packed {
      logic [31:0] hash_word;
      logic [2:0]  out_index;
      logic        last;
   } rsp_type;

   function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
      rotr = (v >> n) | (v << (32 - n));
   endfunction

   function automatic logic [31:0] big_sigma0(input logic [31:0] v);
      big_sigma0 = rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] v);
      big_sigma1 = rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] v);
      small_sigma0 = rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] v);
      small_sigma1 = rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
   endfunction

   function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                          input logic [31:0] g);
      choose = (e & f) ^ (~e & g);
   endfunction

   function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                            input logic [31:0] c);
      majority = (a & b) ^ (a & c) ^ (b & c);
   endfunction

   function automatic logic [31:0] round_k(input logic [ROUND_W-1:0] t);
      logic [31:0] k;
      unique case (t)
         6'd0:  k = 32'h428a2f98;
         6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hb5c0fbcf;
         6'd3:  k = 32'he9b5dba5;
         6'd4:  k = 32'h3956c25b;
         6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4;
         6'd7:  k = 32'hab1c5ed5;
         6'd8:  k = 32'hd807aa98;
         6'd9:  k = 32'h12835b01;
         6'd10: k = 32'h243185be;
         6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74;
         6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7;
         6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1;
         6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6;
         6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f;
         6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc;
         6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152;
         6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8;
         6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3;
         6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351;
         6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85;
         6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc;
         6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354;
         6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e;
         6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1;
         6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70;
         6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819;
         6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585;
         6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116;
         6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c;
         6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3;
         6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f;
         6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee;
         6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814;
         6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa;
         6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7;
         6'd63: k = 32'hc67178f2;
         default: k = 32'h0;
      endcase
      round_k = k;
   endfunction

endpackage

>>> hw/rtl/sha256_block_compress_top.sv
// Channel   Direction  Handshake               Payload
// req       in         req_valid / req_ready   sha256bc_pkg::req_type (op, word_index, data)
// rsp       out        rsp_valid / rsp_ready   sha256bc_pkg::rsp_type (hash_word, out_index, last)
//
// A chaining word or one of the first fifteen message words leaves the block idle, ready for more.
// The sixteenth message word starts a compression of 64 rounds and a chaining add:
// each round runs in issue, part and word phases on the two read ports of the schedule memory.
// The eight result items then leave at one per cycle while rsp_ready is high.
// Reset clears the chaining value and the message word count.
// req_ready is low from the sixteenth word until the last result item is loaded.
module sha256_block_compress_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  sha256bc_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output sha256bc_pkg::rsp_type rsp_payload
);
   import sha256bc_pkg::*;

   localparam logic [ROUND_W-1:0] LastRound = ROUND_W'(ROUNDS - 1);
   localparam logic [HIDX_W-1:0]  LastWord  = HIDX_W'(HASH_WORDS - 1);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_ROUND = 4'b0010,
      ST_ADD   = 4'b0100,
      ST_OUT   = 4'b1000
   } state_type;

   typedef enum logic [2:0] {
      PH_ISSUE = 3'b001,
      PH_PART  = 3'b010,
      PH_WORD  = 3'b100
   } phase_type;

   state_type          state_ff, state_in;
   phase_type          phase_ff, phase_in;
   logic [ROUND_W-1:0] round_ff, round_in;
   logic [WIN_W-1:0]   count_ff, count_in;
   logic [HIDX_W-1:0]  oidx_ff, oidx_in;
   logic               pend_ff, pend_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic [31:0] chain_ff [HASH_WORDS];
   logic [31:0] chain_in [HASH_WORDS];
   logic [31:0] vars_ff [HASH_WORDS];
   logic [31:0] vars_in [HASH_WORDS];
   logic [31:0] part_ff, part_in;
   logic [31:0] hk_ff, hk_in;
   logic [31:0] w_ff, w_in;

   logic [31:0]      sched_mem [BLOCK_WORDS];
   logic [31:0]      rd_a_ff, rd_b_ff;
   logic [WIN_W-1:0] addr_a, addr_b, wr_addr;
   logic [31:0]      wr_data;
   logic             wr_en;

   logic        req_fire, out_load, apply_round;
   logic [31:0] t1, t2;
   logic [WIN_W-1:0] t_lo;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign out_load  = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);
   assign t_lo      = round_ff[WIN_W-1:0];

   // fold in the previous round's word at the head of each round and in the tail state
   assign apply_round = pend_ff &&
                        (((state_ff == ST_ROUND) && (phase_ff == PH_ISSUE)) ||
                         (state_ff == ST_ADD));

   assign t1 = hk_ff + w_ff + big_sigma1(vars_ff[4]) +
               choose(vars_ff[4], vars_ff[5], vars_ff[6]);
   assign t2 = big_sigma0(vars_ff[0]) + majority(vars_ff[0], vars_ff[1], vars_ff[2]);

   always_comb begin
      // first phase fetches w[t-2] and w[t-7], second w[t-15] and w[t-16]
      if (phase_ff == PH_ISSUE) begin
         addr_a = t_lo - WIN_W'(2);
         addr_b = t_lo - WIN_W'(7);
      end else begin
         addr_a = t_lo + WIN_W'(1);
         addr_b = t_lo;
      end
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      round_in     = round_ff;
      count_in     = count_ff;
      oidx_in      = oidx_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      chain_in     = chain_ff;
      vars_in      = vars_ff;
      part_in      = part_ff;
      hk_in        = hk_ff;
      w_in         = w_ff;
      wr_en        = 1'b0;
      wr_addr      = count_ff;
      wr_data      = req_payload.data;

      if (apply_round) begin
         for (int i = HASH_WORDS - 1; i > 0; i--) begin
            vars_in[i] = vars_ff[i-1];
         end
         vars_in[4] = vars_ff[3] + t1;
         vars_in[0] = t1 + t2;
         pend_in    = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_payload.op)
                  OP_CHAIN: chain_in[req_payload.word_index] = req_payload.data;
                  OP_MSG: begin
                     wr_en    = 1'b1;
                     count_in = count_ff + WIN_W'(1);
                     if (count_ff == WIN_W'(BLOCK_WORDS - 1)) begin
                        state_in = ST_ROUND;
                        phase_in = PH_ISSUE;
                        round_in = '0;
                        pend_in  = 1'b0;
                        vars_in  = chain_ff;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_ROUND: begin
            unique case (phase_ff)
               PH_ISSUE: phase_in = PH_PART;
               PH_PART: begin
                  part_in  = small_sigma1(rd_a_ff) + rd_b_ff;
                  hk_in    = vars_ff[7] + round_k(round_ff);
                  phase_in = PH_WORD;
               end
               PH_WORD: begin
                  if (round_ff < ROUND_W'(BLOCK_WORDS)) begin
                     w_in = rd_b_ff;
                  end else begin
                     w_in    = part_ff + small_sigma0(rd_a_ff) + rd_b_ff;
                     wr_en   = 1'b1;
                     wr_addr = t_lo;
                     wr_data = w_in;
                  end
                  pend_in  = 1'b1;
                  phase_in = PH_ISSUE;
                  if (round_ff == LastRound) begin
                     state_in = ST_ADD;
                  end else begin
                     round_in = round_ff + ROUND_W'(1);
                  end
               end
               default: ;
            endcase
         end
         ST_ADD: begin
            // last round lands this cycle; the chaining add follows once it has
            if (!pend_ff) begin
               for (int i = 0; i < HASH_WORDS; i++) begin
                  chain_in[i] = chain_ff[i] + vars_ff[i];
               end
               oidx_in  = '0;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_load) begin
               rsp_valid_in     = 1'b1;
               rsp_in.hash_word = chain_ff[oidx_ff];
               rsp_in.out_index = oidx_ff;
               rsp_in.last      = (oidx_ff == LastWord);
               if (oidx_ff == LastWord) begin
                  state_in = ST_IDLE;
               end else begin
                  oidx_in = oidx_ff + HIDX_W'(1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         sched_mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= sched_mem[addr_a];
      rd_b_ff <= sched_mem[addr_b];
   end

   always_ff @(posedge clock) begin
      vars_ff <= vars_in;
      part_ff <= part_in;
      hk_ff   <= hk_in;
      w_ff    <= w_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_ISSUE;
         round_ff     <= '0;
         count_ff     <= '0;
         oidx_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < HASH_WORDS; i++) begin
            chain_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         round_ff     <= round_in;
         count_ff     <= count_in;
         oidx_ff      <= oidx_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         chain_ff     <= chain_in;
      end
   end

`ifndef SYNTHESIS
   a_count_wraps: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (count_ff == '0))
      else $error("word count not wrapped during compression");

   a_add_after_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADD) |-> (round_ff == LastRound))
      else $error("chaining add entered before the last round");

   a_round_entry: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_payload.op == OP_MSG) && (count_ff == WIN_W'(BLOCK_WORDS - 1)))
      |=> ((state_ff == ST_ROUND) && (round_ff == '0) && !pend_ff))
      else $error("compression did not start on the sixteenth word");

   a_load_in_out: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && $rose(rsp_valid_ff) && ($past(state_ff) == ST_OUT))
      |-> (rsp_ff.out_index == $past(oidx_ff)))
      else $error("result item index out of step");
`endif

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
   import sha256bc_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 250;
   localparam int HOLD_CYCLES  = 400;

   // round constants, first round in the top word
   localparam logic [64*32-1:0] ROUND_CONSTS = {
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   logic    clock;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;

   sha256_block_compress_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // predicted chaining value and partly received block
   logic [31:0] chain_words [8];
   logic [31:0] msg_words [16];
   int          msg_count = 0;
   rsp_type     hash_words_due [$];
   rsp_type     want;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_len      = 0;
   int hold_left     = 0;
   int cycles        = 0;
   int errors        = 0;
   int items_sent    = 0;
   int chain_loads   = 0;
   int blocks_folded = 0;
   int words_checked = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [31:0] rot_right(input logic [31:0] v, input int n);
      return (v >> n) | (v << (32 - n));
   endfunction

   function automatic void fold_block();
      logic [31:0] w [64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
      for (int i = 0; i < 16; i++) w[i] = msg_words[i];
      for (int i = 16; i < 64; i++) begin
         s0 = rot_right(w[i-15], 7) ^ rot_right(w[i-15], 18) ^ (w[i-15] >> 3);
         s1 = rot_right(w[i-2], 17) ^ rot_right(w[i-2], 19) ^ (w[i-2] >> 10);
         w[i] = s1 + w[i-7] + s0 + w[i-16];
      end
      a = chain_words[0]; b = chain_words[1]; c = chain_words[2]; d = chain_words[3];
      e = chain_words[4]; f = chain_words[5]; g = chain_words[6]; h = chain_words[7];
      for (int i = 0; i < 64; i++) begin
         t1 = h + (rot_right(e, 6) ^ rot_right(e, 11) ^ rot_right(e, 25))
              + ((e & f) ^ (~e & g)) + ROUND_CONSTS[(63-i)*32 +: 32] + w[i];
         t2 = (rot_right(a, 2) ^ rot_right(a, 13) ^ rot_right(a, 22))
              + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1;
         d = c; c = b; b = a; a = t1 + t2;
      end
      chain_words[0] += a; chain_words[1] += b; chain_words[2] += c; chain_words[3] += d;
      chain_words[4] += e; chain_words[5] += f; chain_words[6] += g; chain_words[7] += h;
   endfunction

   function automatic void absorb_item(input req_type it);
      rsp_type r;
      items_sent++;
      if (it.op == OP_CHAIN) begin
         chain_words[it.word_index] = it.data;
         chain_loads++;
      end else begin
         msg_words[msg_count] = it.data;
         msg_count++;
         if (msg_count == 16) begin
            msg_count = 0;
            fold_block();
            blocks_folded++;
            for (int i = 0; i < 8; i++) begin
               r.hash_word = chain_words[i];
               r.out_index = 3'(i);
               r.last      = (i == 7);
               hash_words_due.push_back(r);
            end
         end
      end
   endfunction

   function automatic req_type pack_req(input op_type op, input logic [2:0] idx,
                                        input logic [31:0] d);
      req_type it;
      it.op         = op;
      it.word_index = idx;
      it.data       = d;
      return it;
   endfunction

   // entered and left at a falling edge
   task automatic send_item(input req_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= it;
      do @(posedge clock); while (!req_ready);
      absorb_item(it);
      @(negedge clock);
   endtask

   task automatic test_known_block();
      logic [31:0] iv [8];
      logic [31:0] d;
      iv = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
             32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      send_idle_pct = 0;
      stall_pct     = 0;
      for (int i = 0; i < 8; i++) send_item(pack_req(OP_CHAIN, 3'(i), iv[i]));
      for (int i = 0; i < 16; i++) begin
         case (i)
            0:       d = 32'h61626380;
            1:       d = 32'hffffffff;
            3:       d = 32'h80000000;
            4:       d = 32'h00000001;
            15:      d = 32'h00000018;
            default: d = 32'h00000000;
         endcase
         // the index field is ignored on message words
         send_item(pack_req(OP_MSG, (i == 0) ? 3'd7 : 3'd0, d));
         // chaining loads in the middle of a block leave the word count alone
         if (i == 4) begin
            send_item(pack_req(OP_CHAIN, 3'd0, 32'hffffffff));
            send_item(pack_req(OP_CHAIN, 3'd7, 32'h00000000));
         end
      end
   endtask

   task automatic test_random_blocks(input int n_items, input int idle, input int stall);
      req_type     it;
      int unsigned pick;
      send_idle_pct = idle;
      stall_pct     = stall;
      for (int n = 0; n < n_items; n++) begin
         pick = $urandom_range(99);
         it.word_index = 3'($urandom_range(7));
         it.data       = $urandom;
         if (pick < 8) begin
            it.op = OP_CHAIN;
         end else begin
            it.op = OP_MSG;
            if (pick < 14) it.data = 32'h00000000;
            else if (pick < 20) it.data = 32'hffffffff;
         end
         send_item(it);
      end
   endtask

   task automatic test_output_hold();
      int n_msgs;
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_len      = HOLD_CYCLES;
      // enough words to finish the current block and then more, so the input stalls behind the held results
      n_msgs = 16 - msg_count + 6;
      for (int n = 0; n < n_msgs; n++)
         send_item(pack_req(OP_MSG, 3'($urandom_range(7)), $urandom));
      send_item(pack_req(OP_CHAIN, 3'($urandom_range(7)), $urandom));
   endtask

   always @(negedge clock) begin
      if (hold_len != 0) begin
         hold_left = hold_len;
         hold_len  = 0;
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (hash_words_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected result item: hash_word %h out_index %0d last %0b",
                     $time, rsp_payload.hash_word, rsp_payload.out_index, rsp_payload.last);
         end else begin
            want = hash_words_due.pop_front();
            words_checked++;
            if (rsp_payload.hash_word !== want.hash_word) begin
               errors++;
               $display("%0t: hash_word expected %h actual %h",
                        $time, want.hash_word, rsp_payload.hash_word);
            end
            if (rsp_payload.out_index !== want.out_index) begin
               errors++;
               $display("%0t: out_index expected %0d actual %0d",
                        $time, want.out_index, rsp_payload.out_index);
            end
            if (rsp_payload.last !== want.last) begin
               errors++;
               $display("%0t: last expected %0b actual %0b",
                        $time, want.last, rsp_payload.last);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: timed out with %0d result items outstanding",
                  $time, hash_words_due.size());
         $display("FAIL sha256_block_compress_top");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < 8; i++) chain_words[i] = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_known_block();
      test_random_blocks(75, 0, 0);
      test_random_blocks(75, 59, 0);
      test_random_blocks(75, 0, 59);
      test_random_blocks(75, 15, 15);
      test_output_hold();
      req_valid     <= 1'b0;
      send_idle_pct = 0;
      stall_pct     = 0;
      while (hash_words_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (hash_words_due.size() != 0) begin
         errors++;
         $display("%0t: %0d result items never arrived", $time, hash_words_due.size());
      end
      $display("Sent %0d items (%0d chaining loads), compressed %0d blocks, checked %0d words,",
               items_sent, chain_loads, blocks_folded, words_checked);
      $display("under four idle/stall mixes plus one long output hold; %0d mismatches.",
               errors);
      if (errors == 0) begin
         $display("PASS sha256_block_compress_top");
      end else begin
         $display("FAIL sha256_block_compress_top");
      end
      $finish;
   end

endmodule
